// ===== rtl/core/asfd_pkg.sv =====
// ----------------------------------------------------------------------------
// asfd_pkg
// Types and constants shared by the shake and face-down detector.
// ----------------------------------------------------------------------------
package asfd_pkg;

  localparam int AXIS_W     = 15;
  localparam int MAG_W      = 15;
  localparam int SUM_W      = 30;
  localparam int FRAC_BITS  = 8;
  localparam int BASE_W     = 23;
  localparam int DIFF_W     = BASE_W + 1;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 16;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int AVG_SHIFT  = 16;
  localparam int STEP_W     = PROD_W - AVG_SHIFT;
  localparam int SQRT_STEPS = 15;
  localparam int CFG_IDX_W  = 2;

  localparam logic [MUL_B_W-1:0] AVG_WEIGHT  = 16'd3277;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 23'd262144;
  localparam logic [BASE_W-1:0]  BASE_MAX    = 23'h7FFFFF;

  localparam logic [14:0] THR_RESET  = 15'd819;
  localparam logic [14:0] ZLIM_RESET = 15'h7D33;   // -717
  localparam logic [14:0] TOL_RESET  = 15'd410;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAKE_THR = 2'd0,
    REG_Z_LIMIT   = 2'd1,
    REG_LEVEL_TOL = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_START,
    ST_ROOT,
    ST_DIFF,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic sq_en;
    logic sqrt_start;
    logic diff_en;
    logic upd_en;
  } ctrl_t;

  // magnitude of a 15-bit two's complement value; -16384 maps to 16384
  function automatic logic [AXIS_W-1:0] abs15(input logic [AXIS_W-1:0] v);
    abs15 = v[AXIS_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== rtl/core/accel_shake_and_facedown_detect.sv =====
// An accepted item goes through the square, start, root, diff and update states;
// no new item is taken until it is through. The 15-step square root takes most
// of that time; the three squares and the average step share one multiplier.
// in_tready is high only while the sequencer is idle; a waiting result stalls
// the final update step. Synchronous reset restores registers and baseline.
// ----------------------------------------------------------------------------
// accel_shake_and_facedown_detect
// Shake and face-down detector for three-axis acceleration samples.
// ----------------------------------------------------------------------------
module accel_shake_and_facedown_detect (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // accel_x[14:0], accel_y[29:15], accel_z[44:30]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // shaken[0], face_down[1], magnitude[16:2]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import asfd_pkg::*;

  state_t state_r, state_nxt;
  ctrl_t  ctrl;

  logic [14:0] thr_r, zlim_r, tol_r;

  logic [AXIS_W-1:0] ax_r, ay_r, az_r;
  logic [1:0]        cnt_r;
  logic [SUM_W-1:0]  acc_r;
  logic              face_r, shaken_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic [AXIS_W-1:0]         sq_sel;

  logic              out_valid_r;
  logic [MAG_W-1:0]  out_mag_r;
  logic              out_shaken_r, out_face_r;

  logic              sqrt_done;
  logic [MAG_W-1:0]  root;
  logic signed [DIFF_W-1:0] diff;
  logic              shaken;
  logic              out_free;

  logic [AXIS_W-1:0] in_x, in_y, in_z;

  assign in_x     = in_tdata[14:0];
  assign in_y     = in_tdata[29:15];
  assign in_z     = in_tdata[44:30];
  assign out_free = !out_valid_r || out_tready;

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SQUARE;
      ST_SQUARE: if (cnt_r == 2'd3) state_nxt = ST_START;
      ST_START:  state_nxt = ST_ROOT;
      ST_ROOT:   if (sqrt_done) state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE:   ctrl.in_ready   = 1'b1;
      ST_SQUARE: ctrl.sq_en      = 1'b1;
      ST_START:  ctrl.sqrt_start = 1'b1;
      ST_ROOT:   ctrl            = '0;
      ST_DIFF:   ctrl.diff_en    = 1'b1;
      ST_UPDATE: ctrl.upd_en     = out_free;
      default:   ctrl            = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---- configuration ----
  // nothing is taken while reset is held
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      zlim_r <= ZLIM_RESET;
      tol_r  <= TOL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SHAKE_THR: thr_r  <= cfg_data;
        REG_Z_LIMIT:   zlim_r <= cfg_data;
        REG_LEVEL_TOL: tol_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // ---- shared multiplier: squares, then the averaging weight ----
  always_comb begin
    case (cnt_r)
      2'd0:    sq_sel = ax_r;
      2'd1:    sq_sel = ay_r;
      default: sq_sel = az_r;
    endcase
    if (ctrl.diff_en) begin
      mul_a = MUL_A_W'(diff);
      mul_b = AVG_WEIGHT;
    end else begin
      mul_a = $signed({(MUL_A_W-AXIS_W)'(0), sq_sel});
      mul_b = $signed({(MUL_B_W-AXIS_W)'(0), sq_sel});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.sq_en) begin
      cnt_r <= cnt_r + 1'b1;
    end

    if (ctrl.in_ready && in_tvalid) begin
      ax_r   <= abs15(in_x);
      ay_r   <= abs15(in_y);
      az_r   <= abs15(in_z);
      face_r <= ($signed(in_z) < $signed(zlim_r)) &&
                (abs15(in_x) < tol_r) && (abs15(in_y) < tol_r);
    end

    if (ctrl.sq_en || ctrl.diff_en)
      prod_r <= mul_a * mul_b;

    // the product is registered, so it arrives in the cycle after its operand select
    if (ctrl.sq_en) begin
      if (cnt_r == 2'd0) acc_r <= '0;
      else               acc_r <= acc_r + prod_r[SUM_W-1:0];
    end

    if (ctrl.diff_en)
      shaken_r <= shaken;
  end

  asfd_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (ctrl.sqrt_start),
    .radicand_i (acc_r),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  asfd_baseline u_baseline (
    .clk      (clk),
    .rst_n    (rst_n),
    .mag_i    (root),
    .thr_i    (thr_r),
    .prod_i   (prod_r),
    .upd_i    (ctrl.upd_en),
    .diff_o   (diff),
    .shaken_o (shaken)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.upd_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (ctrl.upd_en) begin
      out_mag_r    <= root;
      out_shaken_r <= shaken_r;
      out_face_r   <= face_r;
    end
  end

  assign in_tready  = ctrl.in_ready && rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_mag_r, out_face_r, out_shaken_r};

endmodule

// ===== rtl/core/asfd_sqrt.sv =====
// ----------------------------------------------------------------------------
// asfd_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module asfd_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start_i,
  input  logic [asfd_pkg::SUM_W-1:0]      radicand_i,
  output logic                            done_o,
  output logic [asfd_pkg::MAG_W-1:0]      root_o
);
  import asfd_pkg::*;

  localparam int REM_W = MAG_W + 2;
  localparam int CNT_W = $clog2(SQRT_STEPS);

  logic [SUM_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;

  always_comb begin
    rem_sh   = {rem_r, rad_r[SUM_W-1 -: 2]};
    trial    = {2'b00, q_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i) begin
      rad_nxt  = radicand_i;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt = REM_W'(rem_sh - trial);
        q_nxt   = {q_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = REM_W'(rem_sh);
        q_nxt   = {q_r[MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done_o = done_r;
  assign root_o = q_r;

endmodule

// ===== rtl/core/asfd_baseline.sv =====
// ----------------------------------------------------------------------------
// asfd_baseline
// Running baseline of the magnitude, deviation test and average update.
// ----------------------------------------------------------------------------
module asfd_baseline (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [asfd_pkg::MAG_W-1:0]         mag_i,
  input  logic [14:0]                        thr_i,
  input  logic signed [asfd_pkg::PROD_W-1:0] prod_i,
  input  logic                               upd_i,
  output logic signed [asfd_pkg::DIFF_W-1:0] diff_o,
  output logic                               shaken_o
);
  import asfd_pkg::*;

  logic [BASE_W-1:0]        base_r, base_nxt;
  logic [BASE_W-1:0]        fine;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_neg;
  logic [BASE_W-1:0]        dev;
  logic signed [STEP_W-1:0] step;
  logic signed [STEP_W-1:0] sum;

  always_comb begin
    fine     = {mag_i, FRAC_BITS'(0)};
    diff     = $signed({1'b0, fine}) - $signed({1'b0, base_r});
    diff_neg = ~diff + 1'b1;
    dev      = diff[DIFF_W-1] ? diff_neg[BASE_W-1:0] : diff[BASE_W-1:0];
    shaken_o = dev > {thr_i, FRAC_BITS'(0)};
    diff_o   = diff;

    // arithmetic shift of the product is the floor toward minus infinity
    step = prod_i[PROD_W-1:AVG_SHIFT];
    sum  = $signed({(STEP_W-BASE_W)'(0), base_r}) + step;
    if (sum[STEP_W-1])
      base_nxt = '0;
    else if (|sum[STEP_W-2:BASE_W])
      base_nxt = BASE_MAX;
    else
      base_nxt = sum[BASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (upd_i) begin
      base_r <= base_nxt;
    end
  end

endmodule

// ===== test/asfd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// asfd_checker
// Watches the sample, result and register channels of the shake and face-down
// detector. It keeps its own copy of the registers and of the baseline average,
// predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module asfd_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [47:0]                    in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [23:0]                    out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [asfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [14:0]                    cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             shake_count,
  output int                             facedown_count
);
  import asfd_pkg::*;

  typedef struct packed {
    logic             shaken;
    logic             face_down;
    logic [MAG_W-1:0] magnitude;
  } detect_t;

  detect_t            detect_q[$];
  logic [14:0]        thr_reg;
  logic signed [14:0] zlim_reg;
  logic [14:0]        tol_reg;
  logic [BASE_W-1:0]  baseline;
  int                 errs;
  int                 n_shake;
  int                 n_face;

  // bit-by-bit trial from the top: keep a bit if the square stays within the sum
  function automatic logic [MAG_W-1:0] floor_root(input longint sq_sum);
    logic [MAG_W-1:0] root;
    logic [MAG_W-1:0] trial;
    root = '0;
    for (int b = MAG_W-1; b >= 0; b--) begin
      trial = root | (MAG_W'(1) << b);
      if (longint'(trial) * longint'(trial) <= sq_sum) root = trial;
    end
    return root;
  endfunction

  task automatic predict_sample(input logic [47:0] d);
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    longint  ax;
    longint  ay;
    longint  az;
    longint  diff;
    longint  nb;
    detect_t r;
    x = d[14:0];
    y = d[29:15];
    z = d[44:30];
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    az = (z < 0) ? -longint'(z) : longint'(z);
    r.magnitude = floor_root(ax * ax + ay * ay + az * az);
    diff = (longint'(r.magnitude) << FRAC_BITS) - longint'(baseline);
    r.shaken = ((diff < 0) ? -diff : diff) > (longint'(thr_reg) << FRAC_BITS);
    // arithmetic shift floors toward minus infinity
    nb = longint'(baseline) + ((diff * longint'(AVG_WEIGHT)) >>> AVG_SHIFT);
    if (nb < 0) nb = 0;
    if (nb > longint'(BASE_MAX)) nb = longint'(BASE_MAX);
    baseline = BASE_W'(nb);
    r.face_down = (z < zlim_reg) && (ax < longint'(tol_reg)) && (ay < longint'(tol_reg));
    detect_q.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    detect_t exp_r;
    if (!rst_n) begin
      thr_reg  = THR_RESET;
      zlim_reg = ZLIM_RESET;
      tol_reg  = TOL_RESET;
      baseline = BASE_RESET;
      detect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SHAKE_THR: thr_reg  = cfg_data;
          REG_Z_LIMIT:   zlim_reg = cfg_data;
          REG_LEVEL_TOL: tol_reg  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_sample(in_tdata);
      if (out_tvalid && out_tready) begin
        if (detect_q.size() == 0) begin
          $error("result with no sample waiting: tdata %h", out_tdata);
          errs++;
        end else begin
          exp_r = detect_q.pop_front();
          if (out_tdata[0] !== exp_r.shaken) begin
            $error("shaken: expected %0d, got %0d", exp_r.shaken, out_tdata[0]);
            errs++;
          end
          if (out_tdata[1] !== exp_r.face_down) begin
            $error("face_down: expected %0d, got %0d", exp_r.face_down, out_tdata[1]);
            errs++;
          end
          if (out_tdata[16:2] !== exp_r.magnitude) begin
            $error("magnitude: expected %0d, got %0d", exp_r.magnitude, out_tdata[16:2]);
            errs++;
          end
          n_shake += exp_r.shaken;
          n_face  += exp_r.face_down;
        end
      end
    end
    fail_count     <= errs;
    pending        <= detect_q.size();
    shake_count    <= n_shake;
    facedown_count <= n_face;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the shake and face-down detector: directed edge samples at the
// reset settings, then four phases of mixed random samples, each under its own
// register setting and idle/stall mix. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import asfd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 40;     // settling time after the last result
  localparam int PHASE_ITEMS = 156;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [47:0]          in_tdata;    // accel_x[14:0], accel_y[29:15], accel_z[44:30]
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;   // shaken[0], face_down[1], magnitude[16:2]
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [14:0]          cfg_data;

  int fail_count;
  int pending;
  int shake_count;
  int facedown_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int cycles = 0;
  int cur_zlim = -717;
  int cur_tol = 410;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  accel_shake_and_facedown_detect DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  asfd_checker CHK (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .shake_count    (shake_count),
    .facedown_count (facedown_count)
  );

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int srand(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clip_axis(input int v);
    return (v < -16384) ? -16384 : (v > 16383) ? 16383 : v;
  endfunction

  task automatic send_sample(input int x, input int y, input int z);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {3'b000, 15'(z), 15'(y), 15'(x)};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // holds the sender until every result is back, then lets the last update settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 15'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input int thr, input int zlim, input int tol);
    write_reg(REG_SHAKE_THR, thr);
    write_reg(REG_Z_LIMIT, zlim);
    write_reg(REG_LEVEL_TOL, tol);
    // unused index must leave everything alone
    write_reg(REG_UNUSED, $urandom_range(0, 32767));
    cur_zlim = (zlim > 16383) ? zlim - 32768 : zlim;
    cur_tol  = tol;
  endtask

  task automatic random_sample();
    int a[3];
    int k;
    int lim;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      for (int i = 0; i < 3; i++) a[i] = srand(-16384, 16383);
    end else if (k < 65) begin
      // at rest: gravity on one axis, noise around it
      for (int i = 0; i < 3; i++) a[i] = srand(-300, 300);
      a[$urandom_range(0, 2)] = ($urandom_range(0, 1) ? 1024 : -1024) + srand(-1500, 1500);
    end else if (k < 85) begin
      // near the face-down boundaries of the current setting
      lim = (cur_tol + 40 > 16384) ? 16384 : cur_tol + 40;
      a[0] = clip_axis(srand(-lim, lim));
      a[1] = clip_axis(srand(-lim, lim));
      a[2] = clip_axis(cur_zlim + srand(-400, 400));
    end else begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 3))
          0: a[i] = -16384;
          1: a[i] = 16383;
          2: a[i] = 0;
          default: a[i] = srand(-16384, 16383);
        endcase
      end
    end
    send_sample(a[0], a[1], a[2]);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_SHAKE_THR;
    cfg_data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: threshold 819, z limit -717, tolerance 410, baseline 1 g
    send_sample(0, 0, 1024);
    send_sample(0, 0, 0);
    send_sample(16383, 16383, 16383);
    send_sample(-16384, -16384, -16384);
    send_sample(-16384, 0, 0);
    send_sample(0, -16384, 0);
    send_sample(0, 0, -16384);
    send_sample(0, 0, -1024);
    send_sample(0, 0, -717);
    send_sample(0, 0, -718);
    send_sample(409, -409, -1024);
    send_sample(410, 0, -1024);
    send_sample(0, -410, -1024);
    send_sample(-409, 409, -2000);
    send_sample(-16384, 100, -1024);
    send_sample(16383, -16384, 5);
    send_sample(1, 1, 1);
    send_sample(-1, -1, -1);
    send_sample(0, 0, 1843);
    send_sample(0, 1843, 0);
    send_sample(0, 0, 1024);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          apply_settings(100, -717, 410);
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          apply_settings(0, 0, 16384);
          idle_pct = 64;
          stall_pct = 0;
        end
        2: begin
          apply_settings(32767, -16384, 0);
          idle_pct = 0;
          stall_pct = 64;
        end
        default: begin
          // positive z limit and tolerance above the axis range
          apply_settings($urandom_range(0, 2000), 16383, 32767);
          idle_pct = 29;
          stall_pct = 29;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_sample();
        if (i == PHASE_ITEMS / 2) wait_idle();
      end
    end

    wait_idle();
    $display("Ran %0d samples: reset settings plus four register sets and idle/stall mixes.",
             sent);
    $display("%0d results flagged a shake and %0d lay face down.",
             shake_count, facedown_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
